/* sv/icr_pkg.sv */
// ----------------------------------------------------------------------------
// icr_pkg
// Shared types and constants for the integral class router.
// ----------------------------------------------------------------------------
package icr_pkg;

    localparam int ORB_W            = 8;
    localparam int IDX_W            = 8;
    localparam int BITS_W           = 64;
    localparam int DEF_MAX_ORBITALS = 256;
    localparam int NUM_PAT          = 11;
    localparam int PAT_IDX_W        = 4;

    // Mode codes of an input item
    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // Destination classes
    localparam logic [1:0] CLS_OOOO = 2'd0;
    localparam logic [1:0] CLS_OOVV = 2'd1;
    localparam logic [1:0] CLS_OVOV = 2'd2;
    localparam logic [1:0] CLS_VOOO = 2'd3;

    // Pattern slots, in emission order
    localparam logic [PAT_IDX_W-1:0] PAT_A  = 4'd0;
    localparam logic [PAT_IDX_W-1:0] PAT_C0 = 4'd1;
    localparam logic [PAT_IDX_W-1:0] PAT_C1 = 4'd2;
    localparam logic [PAT_IDX_W-1:0] PAT_D0 = 4'd3;
    localparam logic [PAT_IDX_W-1:0] PAT_D1 = 4'd4;
    localparam logic [PAT_IDX_W-1:0] PAT_D2 = 4'd5;
    localparam logic [PAT_IDX_W-1:0] PAT_D3 = 4'd6;
    localparam logic [PAT_IDX_W-1:0] PAT_E0 = 4'd7;
    localparam logic [PAT_IDX_W-1:0] PAT_E1 = 4'd8;
    localparam logic [PAT_IDX_W-1:0] PAT_E2 = 4'd9;
    localparam logic [PAT_IDX_W-1:0] PAT_E3 = 4'd10;

    typedef struct packed {
        logic             occ;
        logic             vir;
        logic             socc;
        logic [IDX_W-1:0] oidx;
        logic [IDX_W-1:0] vidx;
    } t_entry;

    typedef struct packed {
        logic              mode;
        logic [ORB_W-1:0]  entry_orbital;
        logic              entry_is_occ;
        logic              entry_is_vir;
        logic              entry_is_socc;
        logic [IDX_W-1:0]  entry_occ_index;
        logic [IDX_W-1:0]  entry_vir_index;
        logic [ORB_W-1:0]  orb_p;
        logic [ORB_W-1:0]  orb_q;
        logic [ORB_W-1:0]  orb_r;
        logic [ORB_W-1:0]  orb_s;
        logic [BITS_W-1:0] integral_bits;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        target_class;
        logic [IDX_W-1:0]  out_i;
        logic [IDX_W-1:0]  out_j;
        logic [IDX_W-1:0]  out_k;
        logic [IDX_W-1:0]  out_l;
        logic [BITS_W-1:0] out_bits;
        logic              last_of_run;
    } t_out_item;

endpackage

/* sv/icr_stream_if.sv */
// ----------------------------------------------------------------------------
// icr_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface icr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/integral_class_router_core.sv */
// ----------------------------------------------------------------------------
// integral_class_router_core
// Sorts two-electron integrals into oooo/oovv/ovov/vooo classes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries t_in_item. Mode-load items write one orbital table entry
//   and produce nothing. Mode-classify items look up p, q, r, s and produce
//   zero to eleven t_out_item transfers on o_out, the last one flagged by
//   last_of_run. Results leave in class order A, C, D, E.
// Path: an item's table lookups are registered at its input transfer edge,
//   its pattern decode is registered into the emit stage, and each result
//   passes through the output register. Throughput: one input item per
//   cycle while i_in.ready is high; one result per cycle on o_out while
//   o_out.ready allows, an item holding the emit stage until its last result.
//   The pace is set by the single output register draining the pattern mask.
// Table: two copies of a synchronous RAM, each with two read ports, give
//   four lookups per cycle; every in-range load writes both copies.
// Reset: clears all valid flags; the table is not cleared and an entry
//   must be loaded before it is looked up. No clearing pass is needed.
// Stall: when o_out.ready is low the output register holds, the emit stage
//   and decode stage fill, and i_in.ready drops until room returns.
// ----------------------------------------------------------------------------
module integral_class_router_core
    import icr_pkg::*;
#(
    parameter int MAX_ORBITALS = DEF_MAX_ORBITALS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    icr_stream_if.sink   i_in,
    icr_stream_if.source o_out
);

    localparam int AW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;

    function automatic logic [AW-1:0] to_addr(input logic [ORB_W-1:0] orb);
        logic [AW+ORB_W-1:0] ext;
        ext = {{AW{1'b0}}, orb};
        return ext[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [ORB_W-1:0] orb);
        return (int'(orb) < MAX_ORBITALS);
    endfunction

    // ---------------------------------------------------------------- table
    t_entry mem_a [MAX_ORBITALS];
    t_entry mem_b [MAX_ORBITALS];

    logic     in_accept;
    t_in_item in_d;
    t_entry   load_entry;

    assign in_accept = i_in.valid && i_in.ready;
    assign in_d      = i_in.data;

    always_comb begin
        load_entry.occ  = in_d.entry_is_occ;
        load_entry.vir  = in_d.entry_is_vir;
        load_entry.socc = in_d.entry_is_socc;
        load_entry.oidx = in_d.entry_occ_index;
        load_entry.vidx = in_d.entry_vir_index;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && in_d.mode == MODE_LOAD && in_range(in_d.entry_orbital)) begin
            mem_a[to_addr(in_d.entry_orbital)] <= load_entry;
            mem_b[to_addr(in_d.entry_orbital)] <= load_entry;
        end
    end

    // Reads only on transfer, so read data holds while the stage stalls.
    t_entry             r_rd_p, r_rd_q, r_rd_r, r_rd_s;
    logic [3:0]         r_inr;
    logic [BITS_W-1:0]  r_s1_bits;
    logic               r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_p    <= mem_a[to_addr(in_d.orb_p)];
            r_rd_q    <= mem_a[to_addr(in_d.orb_q)];
            r_rd_r    <= mem_b[to_addr(in_d.orb_r)];
            r_rd_s    <= mem_b[to_addr(in_d.orb_s)];
            r_inr     <= {in_range(in_d.orb_s), in_range(in_d.orb_r),
                          in_range(in_d.orb_q), in_range(in_d.orb_p)};
            r_s1_bits <= in_d.integral_bits;
        end
    end

    // --------------------------------------------------------------- decode
    t_entry              ep, eq, er, es;
    logic [2:0]          socc_cnt;
    logic                all_fire;
    logic [NUM_PAT-1:0]  pat;
    logic [3:0]          d_raw, e_raw, d_sel, e_sel;

    always_comb begin
        ep = r_inr[0] ? r_rd_p : '0;
        eq = r_inr[1] ? r_rd_q : '0;
        er = r_inr[2] ? r_rd_r : '0;
        es = r_inr[3] ? r_rd_s : '0;

        socc_cnt = 3'(ep.socc) + 3'(eq.socc) + 3'(er.socc) + 3'(es.socc);
        all_fire = (socc_cnt > 3'd1);

        pat = '0;
        pat[PAT_A]  = ep.occ && eq.occ && er.occ && es.occ;
        pat[PAT_C0] = ep.occ && eq.occ && er.vir && es.vir;
        pat[PAT_C1] = er.occ && es.occ && ep.vir && eq.vir && (all_fire || !pat[PAT_C0]);

        d_raw[0] = ep.occ && eq.vir && er.occ && es.vir;
        d_raw[1] = eq.occ && ep.vir && er.occ && es.vir;
        d_raw[2] = ep.occ && eq.vir && es.occ && er.vir;
        d_raw[3] = eq.occ && ep.vir && es.occ && er.vir;

        e_raw[0] = ep.vir && eq.occ && er.occ && es.occ;
        e_raw[1] = eq.vir && ep.occ && er.occ && es.occ;
        e_raw[2] = er.vir && es.occ && ep.occ && eq.occ;
        e_raw[3] = es.vir && er.occ && ep.occ && eq.occ;

        // first match only unless several orbitals are singly occupied
        d_sel = all_fire ? d_raw : (d_raw & (~d_raw + 4'd1));
        e_sel = all_fire ? e_raw : (e_raw & (~e_raw + 4'd1));

        pat[PAT_D3:PAT_D0] = d_sel;
        pat[PAT_E3:PAT_E0] = e_sel;
    end

    // ----------------------------------------------------------------- emit
    logic               r_run_valid;
    logic               r_run_all;
    logic [NUM_PAT-1:0] r_mask;
    t_entry             r_ep, r_eq, r_er, r_es;
    logic [BITS_W-1:0]  r_run_bits;

    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               out_free, emit, run_free, s1_advance;
    logic [NUM_PAT-1:0] sel_bit, rest;
    logic [PAT_IDX_W-1:0] sel_idx;
    t_out_item          res;

    assign out_free   = !r_out_valid || o_out.ready;
    assign emit       = r_run_valid && out_free;
    assign sel_bit    = r_mask & (~r_mask + NUM_PAT'(1));
    assign rest       = r_mask & ~sel_bit;
    assign run_free   = !r_run_valid || (emit && rest == '0);
    assign s1_advance = r_s1_valid && (pat == '0 || run_free);
    assign i_in.ready = !r_s1_valid || s1_advance;

    always_comb begin
        sel_idx = '0;
        for (int b = NUM_PAT - 1; b >= 0; b--) begin
            if (r_mask[b]) begin
                sel_idx = PAT_IDX_W'(b);
            end
        end
    end

    always_comb begin
        res.out_bits    = r_run_bits;
        res.last_of_run = (rest == '0);
        case (sel_idx)
            PAT_A: begin
                res.target_class = CLS_OOOO;
                res.out_i = r_ep.oidx; res.out_j = r_eq.oidx;
                res.out_k = r_er.oidx; res.out_l = r_es.oidx;
            end
            PAT_C0: begin
                res.target_class = CLS_OOVV;
                res.out_i = r_ep.oidx; res.out_j = r_eq.oidx;
                res.out_k = r_er.vidx; res.out_l = r_es.vidx;
            end
            PAT_C1: begin
                res.target_class = CLS_OOVV;
                res.out_i = r_er.oidx; res.out_j = r_es.oidx;
                res.out_k = r_ep.vidx; res.out_l = r_eq.vidx;
            end
            PAT_D0: begin
                res.target_class = CLS_OVOV;
                res.out_i = r_ep.oidx; res.out_j = r_eq.vidx;
                res.out_k = r_er.oidx; res.out_l = r_es.vidx;
            end
            PAT_D1: begin
                res.target_class = CLS_OVOV;
                res.out_i = r_eq.oidx; res.out_j = r_ep.vidx;
                res.out_k = r_er.oidx; res.out_l = r_es.vidx;
            end
            PAT_D2: begin
                res.target_class = CLS_OVOV;
                res.out_i = r_ep.oidx; res.out_j = r_eq.vidx;
                res.out_k = r_es.oidx; res.out_l = r_er.vidx;
            end
            PAT_D3: begin
                res.target_class = CLS_OVOV;
                res.out_i = r_eq.oidx; res.out_j = r_ep.vidx;
                res.out_k = r_es.oidx; res.out_l = r_er.vidx;
            end
            PAT_E0: begin
                res.target_class = CLS_VOOO;
                res.out_i = r_ep.vidx; res.out_j = r_eq.oidx;
                res.out_k = r_er.oidx; res.out_l = r_es.oidx;
            end
            PAT_E1: begin
                res.target_class = CLS_VOOO;
                res.out_i = r_eq.vidx; res.out_j = r_ep.oidx;
                res.out_k = r_er.oidx; res.out_l = r_es.oidx;
            end
            PAT_E2: begin
                res.target_class = CLS_VOOO;
                res.out_i = r_er.vidx; res.out_j = r_es.oidx;
                res.out_k = r_ep.oidx; res.out_l = r_eq.oidx;
            end
            PAT_E3: begin
                res.target_class = CLS_VOOO;
                res.out_i = r_es.vidx; res.out_j = r_er.oidx;
                res.out_k = r_ep.oidx; res.out_l = r_eq.oidx;
            end
            default: begin
                res.target_class = CLS_OOOO;
                res.out_i = '0; res.out_j = '0;
                res.out_k = '0; res.out_l = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= (in_d.mode == MODE_CLASSIFY);
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_advance && pat != '0) begin
                r_run_valid <= 1'b1;
            end else if (emit && rest == '0) begin
                r_run_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (s1_advance && pat != '0) begin
            r_mask     <= pat;
            r_run_all  <= all_fire;
            r_ep       <= ep;
            r_eq       <= eq;
            r_er       <= er;
            r_es       <= es;
            r_run_bits <= r_s1_bits;
        end else if (emit) begin
            r_mask <= rest;
        end
        if (emit) begin
            r_out_data <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // ----------------------------------------------------------- assertions
    a_run_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_mask != '0))
        else $error("emit stage valid with empty pattern mask");

    a_first_match_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_valid && !r_run_all) |->
            ($onehot0(r_mask[PAT_D3:PAT_D0]) && $onehot0(r_mask[PAT_E3:PAT_E0])
             && !(r_mask[PAT_C0] && r_mask[PAT_C1])))
        else $error("several patterns of one class pending without multi-socc");

    a_stall_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_run_valid))
        else $error("input stalled while pipeline has room");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && rest == '0 && !(s1_advance && pat != '0)) |=> !r_run_valid)
        else $error("emit stage still busy after last result");

endmodule
